// ===== hdl/format_stream_decimal_printer_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the format stream decimal printer
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ---------------------------------------------------------------------------
`ifndef FORMAT_STREAM_DECIMAL_PRINTER_DEFINES_SVH
`define FORMAT_STREAM_DECIMAL_PRINTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSDP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fsdp_pkg.sv =====
// ---------------------------------------------------------------------------
// fsdp_pkg
// Shared types and constants of the format stream decimal printer.
// ---------------------------------------------------------------------------
package fsdp_pkg;

    localparam int CHAR_W     = 8;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 32;
    localparam int NDIGITS    = 10;
    localparam int DIGIT_W    = 4;
    localparam int IDX_W      = 4;
    localparam int BCD_W      = NDIGITS * DIGIT_W;
    localparam int CONV_STEPS = VAL_W;
    localparam int STEP_W     = 5;

    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // latch the accepted input transaction
        logic conv_init;   // load magnitude, clear BCD, point at top digit
        logic conv_step;   // one double-dabble shift
        logic idx_dec;     // step digit pointer down
        logic load_char;   // echo the plain character
        logic load_err;    // error result with the offending character
        logic load_minus;  // minus sign
        logic load_digit;  // digit under the pointer
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic ch_is_percent;
        logic ch_is_d;
        logic neg;
        logic lead_zero;   // digit under pointer is a leading zero
        logic idx_zero;    // pointer at the units digit
        logic out_free;    // output register can take a result this cycle
    } status_t;

endpackage

// ===== hdl/fsdp_datapath.sv =====
// ---------------------------------------------------------------------------
// fsdp_datapath
// Input capture, binary-to-BCD converter, character count and output register.
// ---------------------------------------------------------------------------
module fsdp_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fsdp_pkg::cmd_t               cmd,
    output fsdp_pkg::status_t            status,
    input  logic [fsdp_pkg::CHAR_W-1:0]  in_ch,
    input  logic [fsdp_pkg::VAL_W-1:0]   in_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fsdp_pkg::CHAR_W-1:0]  out_char,
    output logic                         out_last,
    output logic                         out_error,
    output logic [fsdp_pkg::CNT_W-1:0]   out_count
);
    import fsdp_pkg::*;

    logic [CHAR_W-1:0]                 ch_reg;
    logic [VAL_W-1:0]                  value_reg;
    logic                              neg_reg;
    logic [VAL_W-1:0]                  bin_reg;
    logic [NDIGITS-1:0][DIGIT_W-1:0]   bcd_reg;
    logic [IDX_W-1:0]                  idx_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;

    logic                              out_valid_reg;
    logic [CHAR_W-1:0]                 out_char_reg;
    logic                              out_last_reg;
    logic                              out_error_reg;
    logic [CNT_W-1:0]                  out_count_reg;

    logic [NDIGITS-1:0][DIGIT_W-1:0]   bcd_adj;
    logic [BCD_W-1:0]                  bcd_flat;
    logic [DIGIT_W-1:0]                cur_digit;
    logic                              load_any;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= DIGIT_W'(5)) ? bcd_reg[i] + DIGIT_W'(3) : bcd_reg[i];
        end
        bcd_flat = bcd_adj;
    end

    assign cur_digit  = bcd_reg[idx_reg];
    assign count_next = (count_reg == {CNT_W{1'b1}}) ? count_reg : count_reg + CNT_W'(1);
    assign load_any   = cmd.load_char | cmd.load_err | cmd.load_minus | cmd.load_digit;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg    <= in_ch;
            value_reg <= in_value;
        end
        if (cmd.conv_init)
        begin
            neg_reg <= value_reg[VAL_W-1];
            bin_reg <= value_reg[VAL_W-1] ? (VAL_W'(0) - value_reg) : value_reg;
            bcd_reg <= '0;
            idx_reg <= IDX_W'(NDIGITS - 1);
        end
        else
        begin
            if (cmd.conv_step)
            begin
                bcd_reg <= {bcd_flat[BCD_W-2:0], bin_reg[VAL_W-1]};
                bin_reg <= {bin_reg[VAL_W-2:0], 1'b0};
            end
            if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
        if (cmd.load_char)
        begin
            out_char_reg  <= ch_reg;
            out_last_reg  <= 1'b1;
            out_error_reg <= 1'b0;
            out_count_reg <= count_next;
        end
        else if (cmd.load_err)
        begin
            out_char_reg  <= ch_reg;
            out_last_reg  <= 1'b1;
            out_error_reg <= 1'b1;
            out_count_reg <= count_reg;
        end
        else if (cmd.load_minus)
        begin
            out_char_reg  <= CH_MINUS;
            out_last_reg  <= 1'b0;
            out_error_reg <= 1'b0;
            out_count_reg <= count_next;
        end
        else if (cmd.load_digit)
        begin
            out_char_reg  <= CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit};
            out_last_reg  <= (idx_reg == '0);
            out_error_reg <= 1'b0;
            out_count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_char | cmd.load_minus | cmd.load_digit)
            begin
                count_reg <= count_next;
            end
            if (load_any)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.ch_is_percent = (ch_reg == CH_PERCENT);
    assign status.ch_is_d       = (ch_reg == CH_D);
    assign status.neg           = neg_reg;
    assign status.lead_zero     = (idx_reg != '0) && (cur_digit == '0);
    assign status.idx_zero      = (idx_reg == '0);
    assign status.out_free      = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_error = out_error_reg;
    assign out_count = out_count_reg;

endmodule

// ===== hdl/fsdp_ctrl.sv =====
// ---------------------------------------------------------------------------
// fsdp_ctrl
// Controller state machine: decode, conversion sequencing, emission, halt.
// ---------------------------------------------------------------------------
module fsdp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fsdp_pkg::status_t  status,
    output fsdp_pkg::cmd_t     cmd
);
    import fsdp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT,
        ST_HALT
    } state_t;

    state_t             state_reg, state_next;
    logic               pending_reg, pending_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        step_next    = step_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!pending_reg)
                begin
                    if (status.ch_is_percent)
                    begin
                        pending_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else if (status.out_free)
                    begin
                        cmd.load_char = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else if (status.ch_is_d)
                begin
                    cmd.conv_init = 1'b1;
                    pending_next  = 1'b0;
                    step_next     = '0;
                    state_next    = ST_CONV;
                end
                else if (status.out_free)
                begin
                    cmd.load_err = 1'b1;
                    pending_next = 1'b0;
                    state_next   = ST_HALT;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CONV_STEPS - 1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (status.lead_zero)
                begin
                    cmd.idx_dec = 1'b1;
                end
                else if (status.neg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.load_minus = 1'b1;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_digit = 1'b1;
                    if (status.idx_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                    end
                end
            end
            ST_HALT:
            begin
                state_next = ST_HALT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            step_reg    <= step_next;
        end
    end

    // drop every transaction once halted
    assign in_ready = (state_reg == ST_IDLE) || (state_reg == ST_HALT);

endmodule

// ===== hdl/format_stream_decimal_printer.sv =====
// ---------------------------------------------------------------------------
// format_stream_decimal_printer
// Format-character stream in, ASCII character stream with running count out.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis: one transaction per format character with its
//   argument. Plain characters are echoed; '%' arms a conversion and emits
//   nothing; 'd' after '%' prints the signed argument in decimal; any other
//   character after '%' gives one error result (tuser high) and halts the block.
//   Master stream m_axis: one transaction per character, tlast on the final
//   character caused by an input transaction, count saturating at all ones.
//   Sequence: after acceptance the block decodes the character, and a plain
//   or '%' character then returns it to idle; a plain character waits in
//   decode until the output register is free and is loaded into it then.
//   A %d conversion decodes, shifts all 32 bits of the magnitude through
//   the BCD converter, scans past suppressed leading zeros and then emits
//   the optional minus sign and the digits, each once the output register
//   is free. The converter is a bit-serial double-dabble loop and every
//   character passes through the single output register.
//   Reset clears the pending '%', the halt and the count.
//   A stalled receiver holds the output register; the controller waits
//   before loading the next character, and a new input transaction can be
//   accepted while a finished result still waits.
// ---------------------------------------------------------------------------
module format_stream_decimal_printer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] ch, [39:8] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] char_out, [39:8] count
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] error
);
    import fsdp_pkg::*;

    cmd_t               cmd;
    status_t            status;
    logic [CHAR_W-1:0]  out_char;
    logic [CNT_W-1:0]   out_count;

    // Sequence decode, conversion and emission
    fsdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the transaction, convert it and present results
    fsdp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_ch     (s_axis_tdata[CHAR_W-1:0]),
        .in_value  (s_axis_tdata[CHAR_W+VAL_W-1:CHAR_W]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .out_last  (m_axis_tlast),
        .out_error (m_axis_tuser),
        .out_count (out_count)
    );

    assign m_axis_tdata = {out_count, out_char};

endmodule

// ===== hdl/fsdp_checker.sv =====
// ---------------------------------------------------------------------------
// fsdp_checker
// Port-level assertions for the format stream decimal printer, bound to top.
// ---------------------------------------------------------------------------
`include "format_stream_decimal_printer_defines.svh"

module fsdp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        m_axis_tuser
);

    // stalled result holds
    `FSDP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")

    // an error ends its item
    `FSDP_ASSERT_SAME(a_err_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "error result without tlast")

    // nothing follows an error
    `FSDP_ASSERT_NEXT(a_halt_quiet, m_axis_tvalid && m_axis_tready && m_axis_tuser, !m_axis_tvalid, "output after error")

    // every emitted character is counted
    `FSDP_ASSERT_SAME(a_count_nz, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[39:8] != 32'h0, "character with zero count")

    // a halted block keeps taking and dropping input
    `FSDP_ASSERT_NEXT(a_halt_ready, m_axis_tvalid && m_axis_tready && m_axis_tuser, s_axis_tready, "halted block stalled its input")

endmodule

bind format_stream_decimal_printer fsdp_checker u_fsdp_checker (.*);
